### rtl/core/aeh_pkg.sv
// ----------------------------------------------------------------------------
// aeh_pkg
// shared types and constants for the alignment edge histogram
// ----------------------------------------------------------------------------
package aeh_pkg;

    localparam int KEY_COUNT_DEF = 8192;
    localparam int KEY_W         = 16;
    localparam int POS_W         = 16;
    localparam int CNT_W         = 4;
    localparam int OP_W          = 2;

    localparam logic [CNT_W-1:0] CNT_MAX       = 4'd15;
    localparam logic [CNT_W-1:0] THRESHOLD_RST = 4'd4;

    localparam logic [OP_W-1:0] OP_COUNT    = 2'd0;
    localparam logic [OP_W-1:0] OP_CLASSIFY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 8;

    typedef struct packed {
        logic [KEY_W-1:0] left_key;
        logic [KEY_W-1:0] right_key;
        logic [KEY_W-1:0] centre_key;
    } key_set_t;

    // per-cycle control from the sequencer to each histogram bank
    typedef struct packed {
        logic bump;
        logic clear_wr;
    } bank_ctrl_t;

endpackage

### rtl/core/aeh_key_calc.sv
// ----------------------------------------------------------------------------
// aeh_key_calc
// quantizes 12.4 box coordinates to tenth-of-point histogram keys
// ----------------------------------------------------------------------------
module aeh_key_calc
(
    input  logic [aeh_pkg::POS_W-1:0] left_pos,
    input  logic [aeh_pkg::POS_W-1:0] right_pos,
    output aeh_pkg::key_set_t         keys
);

    logic [19:0] left_x10;
    logic [19:0] right_x10;
    logic [16:0] pos_sum;
    logic [19:0] sum_x5;

    // times ten as shift-add, then drop the four fraction bits
    assign left_x10  = {1'b0, left_pos, 3'b000} + {3'b000, left_pos, 1'b0};
    assign right_x10 = {1'b0, right_pos, 3'b000} + {3'b000, right_pos, 1'b0};
    assign pos_sum   = {1'b0, left_pos} + {1'b0, right_pos};
    assign sum_x5    = {1'b0, pos_sum, 2'b00} + {3'b000, pos_sum};

    assign keys.left_key   = left_x10[19:4];
    assign keys.right_key  = right_x10[19:4];
    assign keys.centre_key = sum_x5[19:4];

endmodule

### rtl/core/aeh_hist_bank.sv
// ----------------------------------------------------------------------------
// aeh_hist_bank
// one histogram: synchronous count memory with read-modify-write and forwarding
// ----------------------------------------------------------------------------
module aeh_hist_bank
#(
    parameter int KEY_COUNT = aeh_pkg::KEY_COUNT_DEF,
    localparam int AW       = $clog2(KEY_COUNT)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [AW-1:0]             rd_key,
    input  logic                      rd_in_range,
    input  logic                      rd_en,
    input  aeh_pkg::bank_ctrl_t       ctrl,
    input  logic [AW-1:0]             clr_addr,
    input  logic [aeh_pkg::CNT_W-1:0] threshold,
    output logic                      aligned
);

    logic [aeh_pkg::CNT_W-1:0] mem [KEY_COUNT];
    logic [aeh_pkg::CNT_W-1:0] rd_data_reg;
    logic [AW-1:0]             key_reg;
    logic                      in_range_reg;
    logic                      fwd_valid_reg;
    logic                      fwd_valid_next;
    logic [AW-1:0]             fwd_addr_reg;
    logic [aeh_pkg::CNT_W-1:0] fwd_data_reg;
    logic [aeh_pkg::CNT_W-1:0] cur_count;
    logic [aeh_pkg::CNT_W-1:0] inc_count;
    logic                      do_bump;

    // a write on the edge of the read leaves the read data stale
    assign cur_count = (fwd_valid_reg && (fwd_addr_reg == key_reg)) ? fwd_data_reg
                                                                     : rd_data_reg;
    assign inc_count = (cur_count == aeh_pkg::CNT_MAX) ? cur_count
                                                       : cur_count + 1'b1;
    assign do_bump        = ctrl.bump && in_range_reg && !ctrl.clear_wr;
    assign fwd_valid_next = do_bump;
    assign aligned        = in_range_reg && (cur_count >= threshold);

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_key];
        if (ctrl.clear_wr)
        begin
            mem[clr_addr] <= '0;
        end
        else if (do_bump)
        begin
            mem[key_reg] <= inc_count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            key_reg      <= rd_key;
            in_range_reg <= rd_in_range;
        end
        fwd_addr_reg <= key_reg;
        fwd_data_reg <= inc_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= fwd_valid_next;
        end
    end

endmodule

### rtl/core/alignment_edge_histogram.sv
// ----------------------------------------------------------------------------
// alignment_edge_histogram
// counts quantized box edges and centres, flags positions shared by many boxes
// ----------------------------------------------------------------------------
// a classify result passes the stage-1 registers, then the output register, before it is on m_tdata
// throughput: count items one per cycle while no clearing pass runs and the output
//   register is free; a classify in stage 1 holds off the next input
// reset and each clear item start a clearing pass over all KEY_COUNT entries (8192
//   by default), one entry of all three memories per cycle, with s_tready low
module alignment_edge_histogram
#(
    parameter int KEY_COUNT = aeh_pkg::KEY_COUNT_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // operation[1:0], left_pos[17:2], right_pos[33:18], zero fill
    input  logic [aeh_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // left_aligned[0], right_aligned[1], centred[2], off_table[3], zero fill
    output logic [aeh_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // min_alignment_count
    input  logic [aeh_pkg::CNT_W-1:0]      cfg_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready
);

    localparam int AW = $clog2(KEY_COUNT);

    logic [aeh_pkg::OP_W-1:0]  in_op;
    logic [aeh_pkg::POS_W-1:0] in_left;
    logic [aeh_pkg::POS_W-1:0] in_right;
    aeh_pkg::key_set_t         keys;
    logic                      left_ok;
    logic                      right_ok;
    logic                      centre_ok;
    logic                      accept;

    logic                      clearing_reg;
    logic                      clearing_next;
    logic [AW-1:0]             clr_cnt_reg;
    logic [AW-1:0]             clr_cnt_next;
    logic                      s1_valid_reg;
    logic [aeh_pkg::OP_W-1:0]  s1_op_reg;
    logic                      s1_off_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [3:0]                out_bits_reg;
    logic [aeh_pkg::CNT_W-1:0] thr_reg;
    aeh_pkg::bank_ctrl_t       bank_ctrl;
    logic                      left_hit;
    logic                      right_hit;
    logic                      centre_hit;
    logic                      s1_classify;

    assign in_op    = s_tdata[1:0];
    assign in_left  = s_tdata[17:2];
    assign in_right = s_tdata[33:18];

    aeh_key_calc u_key_calc
    (
        .left_pos  (in_left),
        .right_pos (in_right),
        .keys      (keys)
    );

    assign left_ok   = {16'b0, keys.left_key} < 32'(KEY_COUNT);
    assign right_ok  = {16'b0, keys.right_key} < 32'(KEY_COUNT);
    assign centre_ok = {16'b0, keys.centre_key} < 32'(KEY_COUNT);

    assign s1_classify = s1_valid_reg && (s1_op_reg == aeh_pkg::OP_CLASSIFY);
    assign s_tready    = !clearing_reg && (!out_valid_reg || m_tready) && !s1_classify;
    assign accept      = s_tvalid && s_tready;
    assign cfg_ready   = 1'b1;

    assign bank_ctrl.bump     = s1_valid_reg && (s1_op_reg == aeh_pkg::OP_COUNT);
    assign bank_ctrl.clear_wr = clearing_reg;

    aeh_hist_bank #(.KEY_COUNT(KEY_COUNT)) u_left_bank
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_key      (left_ok ? keys.left_key[AW-1:0] : '0),
        .rd_in_range (left_ok),
        .rd_en       (accept),
        .ctrl        (bank_ctrl),
        .clr_addr    (clr_cnt_reg),
        .threshold   (thr_reg),
        .aligned     (left_hit)
    );

    aeh_hist_bank #(.KEY_COUNT(KEY_COUNT)) u_right_bank
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_key      (right_ok ? keys.right_key[AW-1:0] : '0),
        .rd_in_range (right_ok),
        .rd_en       (accept),
        .ctrl        (bank_ctrl),
        .clr_addr    (clr_cnt_reg),
        .threshold   (thr_reg),
        .aligned     (right_hit)
    );

    aeh_hist_bank #(.KEY_COUNT(KEY_COUNT)) u_centre_bank
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_key      (centre_ok ? keys.centre_key[AW-1:0] : '0),
        .rd_in_range (centre_ok),
        .rd_en       (accept),
        .ctrl        (bank_ctrl),
        .clr_addr    (clr_cnt_reg),
        .threshold   (thr_reg),
        .aligned     (centre_hit)
    );

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == AW'(KEY_COUNT - 1))
            begin
                clearing_next = 1'b0;
                clr_cnt_next  = '0;
            end
        end
        else if (accept && (in_op == aeh_pkg::OP_CLEAR))
        begin
            clearing_next = 1'b1;
            clr_cnt_next  = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_classify)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            thr_reg       <= aeh_pkg::THRESHOLD_RST;
        end
        else
        begin
            clearing_reg  <= clearing_next;
            clr_cnt_reg   <= clr_cnt_next;
            s1_valid_reg  <= accept;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg  <= in_op;
            s1_off_reg <= !(left_ok && right_ok && centre_ok);
        end
        if (s1_classify)
        begin
            out_bits_reg <= {s1_off_reg, centre_hit, right_hit, left_hit};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_bits_reg};

`ifndef SYNTHESIS
    // no input transfer while the memories are being swept
    assert property (@(posedge clk) disable iff (!rst_n) clearing_reg |-> !s_tready)
        else $error("input accepted during clearing pass");

    // a classify result never lands on a result still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_classify |-> (!out_valid_reg || m_tready))
        else $error("output register overrun");

    // a clear transfer starts the sweep at entry zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_op == aeh_pkg::OP_CLEAR)) |=> (clearing_reg && (clr_cnt_reg == '0)))
        else $error("clear did not start sweep");
`endif

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks alignment_edge_histogram against a behavioral copy of its three
// saturating histograms: directed boxes at the quantization and table limits,
// then random box streams with sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import aeh_pkg::*;

    localparam int               KEY_COUNT    = KEY_COUNT_DEF;
    localparam logic [OP_W-1:0]  OP_UNUSED    = 2'd3;
    localparam int               SETTLE_CYCLES = 6;
    localparam int               IDLE_LIMIT   = 40000;
    localparam int               REPORT_MAX   = 10;

    typedef struct packed {
        logic off_table;
        logic centred;
        logic right_aligned;
        logic left_aligned;
    } align_flags_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [CNT_W-1:0]      cfg_data = '0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;

    // behavioral copy of the block state
    logic [CNT_W-1:0] left_hist   [KEY_COUNT];
    logic [CNT_W-1:0] right_hist  [KEY_COUNT];
    logic [CNT_W-1:0] centre_hist [KEY_COUNT];
    logic [CNT_W-1:0] min_count = THRESHOLD_RST;

    align_flags_t expected_flags[$];
    int           mismatch_count = 0;
    int           sender_idle_pct = 0;
    int           receiver_stall_pct = 0;

    alignment_edge_histogram u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    function automatic void clear_histograms();
        foreach (left_hist[i])
        begin
            left_hist[i]   = '0;
            right_hist[i]  = '0;
            centre_hist[i] = '0;
        end
    endfunction

    // updates the histogram copy for one accepted box, queues a classify result
    function automatic void predict_box(input logic [OP_W-1:0] op,
                                        input logic [POS_W-1:0] left_pos,
                                        input logic [POS_W-1:0] right_pos);
        logic [31:0]  lk;
        logic [31:0]  rk;
        logic [31:0]  ck;
        align_flags_t flags;
        lk = (32'd10 * {16'd0, left_pos}) >> 4;
        rk = (32'd10 * {16'd0, right_pos}) >> 4;
        ck = (32'd5 * ({16'd0, left_pos} + {16'd0, right_pos})) >> 4;
        case (op)
            OP_COUNT:
            begin
                if (lk < KEY_COUNT && left_hist[lk] != CNT_MAX)
                    left_hist[lk] = left_hist[lk] + 1'b1;
                if (rk < KEY_COUNT && right_hist[rk] != CNT_MAX)
                    right_hist[rk] = right_hist[rk] + 1'b1;
                if (ck < KEY_COUNT && centre_hist[ck] != CNT_MAX)
                    centre_hist[ck] = centre_hist[ck] + 1'b1;
            end
            OP_CLASSIFY:
            begin
                flags.left_aligned  = (lk < KEY_COUNT) ? (left_hist[lk] >= min_count) : 1'b0;
                flags.right_aligned = (rk < KEY_COUNT) ? (right_hist[rk] >= min_count) : 1'b0;
                flags.centred       = (ck < KEY_COUNT) ? (centre_hist[ck] >= min_count) : 1'b0;
                flags.off_table     = (lk >= KEY_COUNT) || (rk >= KEY_COUNT) ||
                                      (ck >= KEY_COUNT);
                expected_flags = {expected_flags, flags};
            end
            OP_CLEAR:
            begin
                clear_histograms();
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void report_field(input string field, input logic want,
                                         input logic got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("mismatch at %0t: %s expected %0b, got %0b", $realtime, field,
                     want, got);
    endfunction

    // result checker
    always @(posedge clk)
    begin
        align_flags_t got;
        align_flags_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[3:0];
            if (expected_flags.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result at %0t: %b", $realtime, m_tdata);
            end
            else
            begin
                want = expected_flags.pop_front();
                if (got.left_aligned !== want.left_aligned)
                    report_field("left_aligned", want.left_aligned, got.left_aligned);
                if (got.right_aligned !== want.right_aligned)
                    report_field("right_aligned", want.right_aligned, got.right_aligned);
                if (got.centred !== want.centred)
                    report_field("centred", want.centred, got.centred);
                if (got.off_table !== want.off_table)
                    report_field("off_table", want.off_table, got.off_table);
            end
        end
    end

    // watchdog on cycles without any transfer; covers the clearing pass
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog expired at %0t", $realtime);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_box(input logic [OP_W-1:0] op, input logic [POS_W-1:0] left_pos,
                            input logic [POS_W-1:0] right_pos);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tdata  <= {6'd0, right_pos, left_pos, op};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        predict_box(op, left_pos, right_pos);
    endtask

    // drops valid, waits for every pending result, then lets the pipe settle
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_flags.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_min_count(input logic [CNT_W-1:0] level);
        wait_drained();
        @(negedge clk);
        cfg_data  <= level;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        min_count = level;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // reset threshold, threshold crossing, table limits, clear
    task automatic test_counting_basics();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_box(OP_CLASSIFY, 16'd0, 16'd0);
        repeat (3) send_box(OP_COUNT, 16'd0, 16'd0);
        send_box(OP_CLASSIFY, 16'd0, 16'd0);
        send_box(OP_COUNT, 16'd0, 16'd0);
        // hold the sender until the earlier results are back
        wait_drained();
        send_box(OP_CLASSIFY, 16'd0, 16'd0);
        // largest in-table keys, then the first key past the table
        send_box(OP_COUNT, 16'd13107, 16'd13107);
        send_box(OP_COUNT, 16'd13108, 16'd0);
        send_box(OP_CLASSIFY, 16'd13107, 16'd13107);
        send_box(OP_CLASSIFY, 16'd13108, 16'd0);
        send_box(OP_CLASSIFY, 16'hffff, 16'hffff);
        send_box(OP_CLEAR, 16'd0, 16'd0);
        send_box(OP_CLASSIFY, 16'd0, 16'd0);
    endtask

    // sixteen hits on one key must stay at the maximum count
    task automatic test_saturation();
        write_min_count(CNT_MAX);
        repeat (16) send_box(OP_COUNT, 16'd1234, 16'd4321);
        send_box(OP_CLASSIFY, 16'd1234, 16'd4321);
    endtask

    // zero threshold flags every in-table key, never an off-table one
    task automatic test_zero_threshold();
        write_min_count(4'd0);
        send_box(OP_CLASSIFY, 16'd5000, 16'd6000);
        send_box(OP_CLASSIFY, 16'd40000, 16'd1);
    endtask

    task automatic test_random_boxes(input int item_total, input logic [CNT_W-1:0] level,
                                     input int send_pct, input int stall_pct);
        logic [POS_W-1:0] pool_left  [16];
        logic [POS_W-1:0] pool_right [16];
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] left_pos;
        logic [POS_W-1:0] right_pos;
        int               pick;
        int               slot;
        write_min_count(level);
        sender_idle_pct    = send_pct;
        receiver_stall_pct = stall_pct;
        // a small set of shared positions so that counts build up
        foreach (pool_left[i])
        begin
            pool_left[i]  = ($urandom_range(9) == 0) ? POS_W'($urandom_range(65535))
                                                     : POS_W'($urandom_range(13107));
            pool_right[i] = POS_W'($urandom_range(13107));
        end
        for (int k = 0; k < item_total; k++)
        begin
            pick      = $urandom_range(199);
            slot      = $urandom_range(15);
            left_pos  = pool_left[slot];
            right_pos = pool_right[slot];
            op        = ($urandom_range(99) < 55) ? OP_COUNT : OP_CLASSIFY;
            if (pick < 2)
                op = OP_CLEAR;
            else if (pick < 6)
            begin
                op        = OP_UNUSED;
                left_pos  = POS_W'($urandom_range(65535));
                right_pos = POS_W'($urandom_range(65535));
            end
            else if (pick < 20)
            begin
                left_pos  = POS_W'($urandom_range(65535));
                right_pos = POS_W'($urandom_range(65535));
            end
            else if (pick < 24)
            begin
                pool_left[slot]  = POS_W'($urandom_range(13107));
                pool_right[slot] = POS_W'($urandom_range(13107));
            end
            if (pick == 199)
                wait_drained();
            send_box(op, left_pos, right_pos);
        end
    endtask

    initial
    begin
        clear_histograms();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        test_counting_basics();
        test_saturation();
        test_zero_threshold();
        test_random_boxes(385, 4'd1, 0, 0);
        test_random_boxes(385, 4'd7, 82, 0);
        test_random_boxes(385, CNT_MAX, 0, 82);
        test_random_boxes(385, 4'd3, 23, 23);

        wait_drained();
        if (mismatch_count == 0 && expected_flags.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/core/aeh_pkg.sv
rtl/core/aeh_key_calc.sv
rtl/core/aeh_hist_bank.sv
rtl/core/alignment_edge_histogram.sv
bench/testbench.sv
